>>> hw/rtl/lfsd_pkg.sv
// ============================================================================
// LED frame stream decoder - shared definitions
// Types, status codes and fixed constants used by the decoder modules.
// ============================================================================
package lfsd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Fixed limits and formats
    localparam int MAX_FRAMES    = 16;
    localparam int FRAMES_W      = 5;
    localparam int HEADER_BYTES  = 2;
    localparam int RECORD_LAST   = 4;   // offset of the fifth byte in a record

    localparam logic [15:0]         MAX_LEDS_RESET   = 16'd409;
    localparam logic [FRAMES_W-1:0] FRAMES_EXP_RESET = 5'd1;
    localparam logic [15:0]         TOTAL_SAT        = 16'hFFFF;

    // Result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_MAX_LEDS   = 1'b0;
    localparam logic REG_FRAMES_EXP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_LONG     = 3'd1,
        ST_TOO_MANY     = 3'd2,
        ST_MID_FRAME    = 3'd3,
        ST_FRAME_COUNT  = 3'd4,
        ST_UNCONFIGURED = 3'd5
    } status_code_t;

    // One queue entry: the results caused by one input byte
    typedef struct packed {
        logic          has_rec;
        logic          has_stat;
        logic [15:0]   led_id;
        logic [23:0]   led_color;
        status_code_t  code;
        logic [15:0]   total;
    } lfsd_entry_t;

endpackage

>>> hw/rtl/lfsd_front.sv
// ============================================================================
// LED frame stream decoder - front end
// Parses each accepted byte, tracks frame/record state and latches errors.
// ============================================================================
module lfsd_front #(
    parameter int MAX_FRAME_BYTES = lfsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [15:0]                   max_leds,
    input  logic [lfsd_pkg::FRAMES_W-1:0] frames_expected,
    output logic                          q_push,
    output lfsd_pkg::lfsd_entry_t         q_entry
);
    import lfsd_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = POS_W + 1;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          hi_reg, hi_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [2:0]          idx_reg, idx_next;
    logic [31:0]         rec_reg, rec_next;
    logic [FRAMES_W-1:0] seen_reg, seen_next;
    status_code_t        err_reg, err_next;
    logic [15:0]         total_reg, total_next;

    logic [FRAMES_W-1:0] eff_frames;
    logic [15:0]         hdr_cnt;
    logic [18:0]         hdr_len;
    logic [LEN_W-1:0]    pos_inc;
    logic                rec_valid;
    status_code_t        code;

    assign eff_frames = (int'(frames_expected) > MAX_FRAMES) ?
                        FRAMES_W'(MAX_FRAMES) : frames_expected;
    assign hdr_cnt = {hi_reg, data_byte};
    // 2 + 5 * count
    assign hdr_len = 19'(HEADER_BYTES) + {1'b0, hdr_cnt, 2'b00} + {3'b000, hdr_cnt};
    assign pos_inc = {1'b0, pos_reg} + LEN_W'(1);

    always_comb
    begin
        pos_next   = pos_reg;
        hi_next    = hi_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        rec_next   = rec_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        err_next   = err_reg;
        rec_valid  = 1'b0;

        if (err_next == ST_OK && max_leds == 16'd0)
            err_next = ST_UNCONFIGURED;

        if (err_next == ST_OK)
        begin
            if (pos_reg == POS_W'(0))
            begin
                if (seen_reg >= eff_frames)
                    err_next = ST_FRAME_COUNT;
                else
                begin
                    hi_next  = data_byte;
                    pos_next = POS_W'(1);
                end
            end
            else if (pos_reg == POS_W'(1))
            begin
                if (hdr_len > 19'(MAX_FRAME_BYTES))
                    err_next = ST_TOO_LONG;
                else if (hdr_cnt > max_leds)
                    err_next = ST_TOO_MANY;
                else if (hdr_cnt == 16'd0)
                begin
                    seen_next = seen_reg + FRAMES_W'(1);
                    pos_next  = POS_W'(0);
                end
                else
                begin
                    pos_next = POS_W'(HEADER_BYTES);
                    idx_next = 3'd0;
                    rec_next = 32'd0;
                    len_next = hdr_len[LEN_W-1:0];
                end
            end
            else
            begin
                if (idx_reg < 3'(RECORD_LAST))
                begin
                    rec_next = {rec_reg[23:0], data_byte};
                    idx_next = idx_reg + 3'd1;
                end
                else
                begin
                    rec_valid = 1'b1;
                    if (total_reg != TOTAL_SAT)
                        total_next = total_reg + 16'd1;
                    idx_next = 3'd0;
                    rec_next = 32'd0;
                end
                if (pos_inc >= len_reg)
                begin
                    seen_next = seen_reg + FRAMES_W'(1);
                    pos_next  = POS_W'(0);
                    idx_next  = 3'd0;
                end
                else
                    pos_next = pos_inc[POS_W-1:0];
            end
        end

        // End-of-stream verdict, taken on the updated state
        if (err_next != ST_OK)
            code = err_next;
        else if (pos_next != POS_W'(0))
            code = ST_MID_FRAME;
        else if (seen_next != eff_frames)
            code = ST_FRAME_COUNT;
        else
            code = ST_OK;
    end

    assign q_push             = accept && (rec_valid || last_byte);
    assign q_entry.has_rec    = rec_valid;
    assign q_entry.has_stat   = last_byte;
    assign q_entry.led_id     = rec_reg[31:16];
    assign q_entry.led_color  = {rec_reg[15:0], data_byte};
    assign q_entry.code       = code;
    assign q_entry.total      = total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hi_reg    <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            rec_reg   <= '0;
            seen_reg  <= '0;
            err_reg   <= ST_OK;
            total_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                hi_reg    <= '0;
                len_reg   <= '0;
                idx_reg   <= '0;
                rec_reg   <= '0;
                seen_reg  <= '0;
                err_reg   <= ST_OK;
                total_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                hi_reg    <= hi_next;
                len_reg   <= len_next;
                idx_reg   <= idx_next;
                rec_reg   <= rec_next;
                seen_reg  <= seen_next;
                err_reg   <= err_next;
                total_reg <= total_next;
            end
        end
    end

    // A latched error only clears at the end of the stream
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(accept && last_byte)) |=> (err_reg == $past(err_reg)))
        else $error("error latch changed mid-stream");

    // Outside the record area no record byte may be pending
    a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_W'(0) || pos_reg == POS_W'(1)) |-> (idx_reg == 3'd0))
        else $error("record offset set outside record area");

endmodule

>>> hw/rtl/lfsd_queue.sv
// ============================================================================
// LED frame stream decoder - entry queue
// Small register FIFO between the front end and the result stage.
// ============================================================================
module lfsd_queue #(
    parameter int DEPTH = lfsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lfsd_pkg::lfsd_entry_t wr_entry,
    output logic                  full,
    input  logic                  pop,
    output lfsd_pkg::lfsd_entry_t rd_entry,
    output logic                  empty
);
    import lfsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lfsd_entry_t     mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == CW'(0));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

>>> hw/rtl/lfsd_back.sv
// ============================================================================
// LED frame stream decoder - result stage
// Expands each queue entry into one or two results in an output register.
// ============================================================================
module lfsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  lfsd_pkg::lfsd_entry_t q_entry,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  item_kind,
    output logic [15:0]           led_id,
    output logic [23:0]           led_color,
    output logic [2:0]            status_code,
    output logic [15:0]           led_total,
    output logic                  run_end
);
    import lfsd_pkg::*;

    logic          out_valid_reg;
    logic          kind_reg;
    logic [15:0]   id_reg;
    logic [23:0]   color_reg;
    status_code_t  code_reg;
    logic [15:0]   total_reg;
    logic          end_reg;
    // status still owed after a record
    logic          pend_reg;
    status_code_t  pend_code_reg;
    logic [15:0]   pend_total_reg;
    logic          load;

    assign load  = !out_valid_reg || pop;
    assign q_pop = load && !pend_reg && !q_empty;

    assign empty       = !out_valid_reg;
    assign item_kind   = kind_reg;
    assign led_id      = id_reg;
    assign led_color   = color_reg;
    assign status_code = code_reg;
    assign led_total   = total_reg;
    assign run_end     = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            kind_reg       <= KIND_RECORD;
            id_reg         <= '0;
            color_reg      <= '0;
            code_reg       <= ST_OK;
            total_reg      <= '0;
            end_reg        <= 1'b0;
            pend_code_reg  <= ST_OK;
            pend_total_reg <= '0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
                kind_reg      <= KIND_STATUS;
                id_reg        <= '0;
                color_reg     <= '0;
                code_reg      <= pend_code_reg;
                total_reg     <= pend_total_reg;
                end_reg       <= 1'b1;
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= q_entry.total;
                if (q_entry.has_rec)
                begin
                    kind_reg       <= KIND_RECORD;
                    id_reg         <= q_entry.led_id;
                    color_reg      <= q_entry.led_color;
                    code_reg       <= ST_OK;
                    end_reg        <= !q_entry.has_stat;
                    pend_reg       <= q_entry.has_stat;
                    pend_code_reg  <= q_entry.code;
                    pend_total_reg <= q_entry.total;
                end
                else
                begin
                    kind_reg  <= KIND_STATUS;
                    id_reg    <= '0;
                    color_reg <= '0;
                    code_reg  <= q_entry.code;
                    end_reg   <= 1'b1;
                end
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    a_pend_behind_rec: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && kind_reg == KIND_RECORD))
        else $error("pending status without a record in front");

    a_rec_then_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_RECORD && !end_reg) |-> pend_reg)
        else $error("record marked not last but no status pending");

endmodule

>>> hw/rtl/led_frame_stream_decoder_top.sv
// ============================================================================
// LED frame stream decoder - top level
// Decodes concatenated LED frames into records and an end-of-stream status.
// ============================================================================
//
//  Channel   Direction  Handshake                      Payload
//  -------   ---------  -----------------------------  ------------------------
//  input     in         push / full                    data_byte, last_byte
//  results   out        empty / pop                    item_kind, led_id,
//                                                      led_color, status_code,
//                                                      led_total, run_end
//  config    in         APB psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  One byte is taken per cycle while full is low; its state update is done in
//  the cycle it is accepted. Results leave at one per cycle from a registered
//  output while the consumer pops; a byte that ends a record and the stream
//  gives two results. full rises only when the entry queue between parser and
//  result stage is full, i.e. when the consumer stalls for long enough. Reset
//  clears the stream state and the queue and loads max_leds = 409 and
//  frames_expected = 1. The stream state also clears after every last byte.
//
module led_frame_stream_decoder_top #(
    parameter int MAX_FRAME_BYTES = lfsd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH     = lfsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // results
    output logic        empty,
    input  logic        pop,
    output logic        item_kind,
    output logic [15:0] led_id,
    output logic [23:0] led_color,
    output logic [2:0]  status_code,
    output logic [15:0] led_total,
    output logic        run_end,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfsd_pkg::*;

    logic [15:0]         max_leds_reg;
    logic [FRAMES_W-1:0] frames_exp_reg;
    logic                cfg_wr;
    logic                accept;
    logic                q_push, q_pop, q_empty;
    lfsd_entry_t         q_wr_entry, q_rd_entry;

    // Registers sit at 4-byte spacing, so paddr[2] picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_LEDS) ? {16'd0, max_leds_reg}
                                                : {{(32-FRAMES_W){1'b0}}, frames_exp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_leds_reg   <= MAX_LEDS_RESET;
            frames_exp_reg <= FRAMES_EXP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_LEDS)
                max_leds_reg <= pwdata[15:0];
            else
                frames_exp_reg <= pwdata[FRAMES_W-1:0];
        end
    end

    // Input transaction: push while the queue has room
    assign accept = push && !full;

    lfsd_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .max_leds        (max_leds_reg),
        .frames_expected (frames_exp_reg),
        .q_push          (q_push),
        .q_entry         (q_wr_entry)
    );

    lfsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    lfsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_entry     (q_rd_entry),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .item_kind   (item_kind),
        .led_id      (led_id),
        .led_color   (led_color),
        .status_code (status_code),
        .led_total   (led_total),
        .run_end     (run_end)
    );

endmodule
